[hdl/astc_pkg.sv]
package astc_pkg;

    // Table geometry.
    localparam int SLOTS     = 64;
    localparam int SLOT_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Field widths.
    localparam int WORD_BITS      = 32;
    localparam int KIND_BITS      = 2;
    localparam int CFG_INDEX_BITS = 1;

    // Reset values.
    localparam logic [WORD_BITS-1:0] WINDOW_START_RESET = 32'h0040_0000;
    localparam logic [WORD_BITS-1:0] WINDOW_END_RESET   = 32'hBFFF_FFFF;
    localparam logic [WORD_BITS-1:0] COUNTER_RESET      = 32'h0000_0001;

    // Request codes.
    typedef enum logic [KIND_BITS-1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_CREATE = 2'd1,
        KIND_QUERY  = 2'd2,
        KIND_CHECK  = 2'd3
    } kind_t;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_WINDOW_START = 1'b0,
        REG_WINDOW_END   = 1'b1
    } cfg_reg_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CREATE,
        ST_LOOKUP,
        ST_REPLY
    } state_t;

endpackage

[hdl/address_space_table_checker_unit.sv]
// Address-space table checker.
// Requests arrive on the input channel (in_valid/in_stall, fields kind,
// directory_word, space_id, start_address, span_length); each request gives
// exactly one reply on the output channel (out_valid/out_stall, fields ok and
// assigned_id). The user window registers are written through the plain
// write port (cfg_write, cfg_index, cfg_data); the user must write them only
// while the block is idle, which the block itself does not enforce. A clear
// request goes straight to its reply. A create request walks the used bits
// one slot per cycle. A query or check request reads one id per cycle from
// the id memory, whose registered read port adds a compare stage.
// One request is worked on at a time, so the slot walk sets the rate; the
// next request is taken as soon as the reply has moved to the output register.
// Reset clears every used bit at once, sets the id counter to 1 and the
// window to its defaults; no clearing pass is needed.
// When the receiver stalls, the reply waits in the output register while the
// next request is worked on; a second reply waits until the first transfers.
module address_space_table_checker_unit
    import astc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [KIND_BITS-1:0]      kind,
    input  logic [WORD_BITS-1:0]      directory_word,
    input  logic [WORD_BITS-1:0]      space_id,
    input  logic [WORD_BITS-1:0]      start_address,
    input  logic [WORD_BITS-1:0]      span_length,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      ok,
    output logic [WORD_BITS-1:0]      assigned_id,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [WORD_BITS-1:0]      cfg_data
);

    localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(SLOTS - 1);

    // Slot storage: ids and directories in memories, used bits in flops.
    logic [WORD_BITS-1:0] ident_mem [SLOTS];
    logic [WORD_BITS-1:0] dir_mem   [SLOTS];
    logic [WORD_BITS-1:0] rd_ident_reg;
    logic                 mem_we;
    logic                 mem_re;

    logic [SLOTS-1:0]     used_reg, used_next;
    logic [WORD_BITS-1:0] counter_reg, counter_next;
    logic [WORD_BITS-1:0] win_start_reg, win_end_reg;

    state_t               state_reg, state_next;
    logic [SLOT_BITS-1:0] idx_reg, idx_next;
    logic                 issue_done_reg, issue_done_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic                 pend_used_reg, pend_used_next;
    logic                 pend_last_reg, pend_last_next;

    // Request held for the duration of its work.
    kind_t                kind_reg;
    logic [WORD_BITS-1:0] dir_reg, id_reg, addr_reg, len_reg;
    logic                 fit_reg, fit_next;

    // Reply waiting for the output register, and the output register.
    logic                 res_ok_reg, res_ok_next;
    logic [WORD_BITS-1:0] res_id_reg, res_id_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_ok_reg;
    logic [WORD_BITS-1:0] out_id_reg;
    logic                 out_load;

    logic                 in_xfer;
    logic                 id_match;
    logic [WORD_BITS-1:0] room;
    logic [WORD_BITS-1:0] limit;
    logic [WORD_BITS-1:0] range_end;

    assign in_stall    = (state_reg != ST_IDLE);
    assign in_xfer     = in_valid && !in_stall;
    assign out_valid   = out_valid_reg;
    assign ok          = out_ok_reg;
    assign assigned_id = out_id_reg;

    // Window test with 32-bit wrapping sums, registered for the compare stage.
    assign room      = win_end_reg - addr_reg + WORD_BITS'(1);
    assign limit     = win_end_reg + WORD_BITS'(1);
    assign range_end = addr_reg + len_reg;
    assign fit_next  = !(addr_reg < win_start_reg) && !(len_reg > room)
                       && !(range_end > limit);

    // A used slot whose id equals the requested one, seen in the cycle after its read.
    assign id_match = pend_valid_reg && pend_used_reg && (rd_ident_reg == id_reg);

    // Sequencer: next state, slot walk and reply.
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        issue_done_next = issue_done_reg;
        pend_valid_next = 1'b0;
        pend_used_next  = used_reg[idx_reg];
        pend_last_next  = (idx_reg == LAST_SLOT);
        used_next       = used_reg;
        counter_next    = counter_reg;
        res_ok_next     = res_ok_reg;
        res_id_next     = res_id_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        out_load        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                idx_next        = '0;
                issue_done_next = 1'b0;
                if (in_xfer)
                begin
                    case (kind_t'(kind))
                        KIND_CLEAR:
                        begin
                            used_next    = '0;
                            counter_next = COUNTER_RESET;
                            res_ok_next  = 1'b1;
                            res_id_next  = '0;
                            state_next   = ST_REPLY;
                        end
                        KIND_CREATE: state_next = ST_CREATE;
                        default:     state_next = ST_LOOKUP;
                    endcase
                end
            end

            ST_CREATE:
            begin
                if (!used_reg[idx_reg])
                begin
                    mem_we             = 1'b1;
                    used_next[idx_reg] = 1'b1;
                    counter_next       = counter_reg + WORD_BITS'(1);
                    res_ok_next        = 1'b1;
                    res_id_next        = counter_reg;
                    state_next         = ST_REPLY;
                end
                else if (idx_reg == LAST_SLOT)
                begin
                    res_ok_next = 1'b0;
                    res_id_next = '0;
                    state_next  = ST_REPLY;
                end
                else
                begin
                    idx_next = idx_reg + SLOT_BITS'(1);
                end
            end

            ST_LOOKUP:
            begin
                // Issue one read per cycle until the last slot has been read.
                if (!issue_done_reg)
                begin
                    mem_re          = 1'b1;
                    pend_valid_next = 1'b1;
                    if (idx_reg == LAST_SLOT)
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + SLOT_BITS'(1);
                    end
                end
                // Compare the id that came back; the first match ends the walk.
                if (id_match)
                begin
                    res_ok_next = (kind_reg == KIND_QUERY) ? 1'b1 : fit_reg;
                    res_id_next = '0;
                    state_next  = ST_REPLY;
                end
                else if (pend_valid_reg && pend_last_reg)
                begin
                    res_ok_next = 1'b0;
                    res_id_next = '0;
                    state_next  = ST_REPLY;
                end
            end

            ST_REPLY:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase

        // Output register holds its reply until the receiver takes it.
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            issue_done_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            used_reg       <= '0;
            counter_reg    <= COUNTER_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            issue_done_reg <= issue_done_next;
            pend_valid_reg <= pend_valid_next;
            used_reg       <= used_next;
            counter_reg    <= counter_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Window registers, written through the configuration port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_start_reg <= WINDOW_START_RESET;
            win_end_reg   <= WINDOW_END_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_WINDOW_START: win_start_reg <= cfg_data;
                REG_WINDOW_END:   win_end_reg   <= cfg_data;
                default:          win_end_reg   <= win_end_reg;
            endcase
        end
    end

    // Payload registers: the request, the walk pipeline and the replies.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            kind_reg <= kind_t'(kind);
            dir_reg  <= directory_word;
            id_reg   <= space_id;
            addr_reg <= start_address;
            len_reg  <= span_length;
        end
        fit_reg       <= fit_next;
        pend_used_reg <= pend_used_next;
        pend_last_reg <= pend_last_next;
        res_ok_reg    <= res_ok_next;
        res_id_reg    <= res_id_next;
        if (out_load)
        begin
            out_ok_reg <= res_ok_reg;
            out_id_reg <= res_id_reg;
        end
    end

    // Slot memories: one write port, one registered read port on the ids.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ident_mem[idx_reg] <= counter_reg;
            dir_mem[idx_reg]   <= dir_reg;
        end
        if (mem_re)
        begin
            rd_ident_reg <= ident_mem[idx_reg];
        end
    end

endmodule
